/* design/multi_slot_interval_timer_defines.svh */
// Assertion macros for the multi-slot interval timer checker.
// No dependencies; taken in by the checker file through `include.
`ifndef MULTI_SLOT_INTERVAL_TIMER_DEFINES_SVH
`define MULTI_SLOT_INTERVAL_TIMER_DEFINES_SVH

// Same-cycle implication, masked while reset is held
`define MSIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msit checker: implication failed");

// Next-cycle implication, live during reset as well
`define MSIT_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("msit checker: next-cycle check failed");

`endif

/* design/msit_pkg.sv */
// Shared types, codes and helpers for the multi-slot interval timer.
// No dependencies; imported by every module of the block.
package msit_pkg;

    // Slot table size and derived index width
    localparam int SLOTS = 8;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Action codes on the input beat
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_SET       = 2'd0;
    localparam logic [1:0] KIND_FIRE      = 2'd1;
    localparam logic [1:0] KIND_CLEAR     = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_ms;
        logic [15:0]        interval;
        logic [15:0]        repeat_req;
        logic [7:0]         handler;
        logic signed [15:0] argument;
        logic [15:0]        timer_id;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        result_id;
        logic               full_res;
        logic [2:0]         slot;
        logic [7:0]         fired_handler;
        logic signed [15:0] fired_argument;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SET,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [31:0]        now_ms;
        logic [15:0]        interval;
        logic [15:0]        repeat_req;
        logic [7:0]         handler;
        logic signed [15:0] argument;
        logic [15:0]        timer_id;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } t_bstate;

    // Report a slot index modulo 8
    function automatic logic [2:0] to_slot_field(input logic [IDX_W-1:0] idx);
        logic [5:0] w;
        w = 6'(idx);
        return w[2:0];
    endfunction

endpackage

/* design/multi_slot_interval_timer.sv */
// Multi-slot interval timer: eight timer slots set, cleared and ticked by command.
//
// Input channel: a beat (action, now_ms and the set/clear fields) is taken at a
// clock edge with start high and busy low. Unused action codes are dropped and
// give no result. A two-entry command queue sits behind the decoder, so busy
// rises only while it is full.
// Result channel: o_valid marks a beat on o_result for exactly one cycle; the
// receiver cannot stall it. o_result.last marks the final beat of a command.
// A set or clear answers with one beat, registered through the queue and the
// result register. A tick scans one slot per cycle through the back end's slot
// table, giving a fire beat for each slot that expires, then a tick-done beat;
// no new command is popped until a tick is done; a set or clear leaves it idle.
// Reset (i_rst_n low, synchronous) frees all slots, zeroes the id counter and
// empties the queue; the block takes commands in the first cycle after reset.
// Depends on msit_pkg, msit_front, msit_queue and msit_back.
module multi_slot_interval_timer
    import msit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_cmd,
    output logic o_valid,
    output t_out o_result
);

    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    t_cmd f_cmd;
    t_cmd q_cmd;

    // Decode and admit beats
    msit_front u_front (
        .start    (start),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .busy     (busy),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    // Buffer commands between front and back
    msit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_full  (q_full)
    );

    // Run commands against the slot table
    msit_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

/* design/msit_front.sv */
// Front end: takes input beats, decodes the action and pushes commands.
// Depends on msit_pkg.
module msit_front
    import msit_pkg::*;
(
    input  logic start,
    input  t_in  i_cmd,
    input  logic i_q_full,
    output logic busy,
    output logic o_push,
    output t_cmd o_cmd
);

    logic known;
    t_op  op;

    // Decode the action; an unused code is dropped without a result
    always_comb begin
        known = 1'b1;
        op    = OP_TICK;
        unique case (i_cmd.action)
            ACT_TICK:  op = OP_TICK;
            ACT_SET:   op = OP_SET;
            ACT_CLEAR: op = OP_CLEAR;
            default:   known = 1'b0;
        endcase
    end

    // Stall the sender while the queue is full
    assign busy   = i_q_full;
    assign o_push = start && !i_q_full && known;

    // Pack the command for the back end
    always_comb begin
        o_cmd.op         = op;
        o_cmd.now_ms     = i_cmd.now_ms;
        o_cmd.interval   = i_cmd.interval;
        o_cmd.repeat_req = i_cmd.repeat_req;
        o_cmd.handler    = i_cmd.handler;
        o_cmd.argument   = i_cmd.argument;
        o_cmd.timer_id   = i_cmd.timer_id;
    end

endmodule

/* design/msit_queue.sv */
// Short command queue between the front and the back of the timer.
// Depends on msit_pkg.
module msit_queue
    import msit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd,
    output logic o_full
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_cmd   = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Hold queued beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* design/msit_back.sv */
// Back end: slot table, id counter and the sequencer that runs commands.
// Depends on msit_pkg; fed by msit_queue.
module msit_back
    import msit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_valid,
    output t_out o_result
);

    // Slot table
    logic               r_running  [SLOTS];
    logic [15:0]        r_id       [SLOTS];
    logic [15:0]        r_interval [SLOTS];
    logic [31:0]        r_last     [SLOTS];
    logic [15:0]        r_repeat   [SLOTS];
    logic [15:0]        r_count    [SLOTS];
    logic [7:0]         r_handler  [SLOTS];
    logic signed [15:0] r_arg      [SLOTS];

    logic [15:0]      r_id_ctr;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_now;
    t_bstate          r_state;
    t_bstate          n_state;
    logic             r_valid;
    logic             n_valid;
    t_out             r_result;
    t_out             n_result;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      elapsed;
    logic [15:0]      count_inc;
    logic             fire_now;
    logic             done_now;
    logic             do_set;
    logic             do_clear;
    logic             do_tick;
    logic [15:0]      next_id;

    // Find the lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_running[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Evaluate the slot under the scan pointer
    assign elapsed   = r_now - r_last[r_idx];
    assign count_inc = r_count[r_idx] + 16'd1;
    assign fire_now  = r_running[r_idx] && (elapsed >= {16'd0, r_interval[r_idx]});
    assign done_now  = (r_repeat[r_idx] != 16'd0) && (r_repeat[r_idx] == count_inc);
    assign next_id   = r_id_ctr + 16'd1;

    // Command strobes from the queue head
    assign o_q_pop  = (r_state == B_IDLE) && i_q_valid;
    assign do_set   = o_q_pop && (i_q_cmd.op == OP_SET);
    assign do_clear = o_q_pop && (i_q_cmd.op == OP_CLEAR);
    assign do_tick  = o_q_pop && (i_q_cmd.op == OP_TICK);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (do_tick) begin
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = B_DONE;
                end
            end
            B_DONE:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Result beat for the next cycle
    always_comb begin
        n_valid  = 1'b0;
        n_result = '0;
        unique case (r_state)
            B_IDLE: begin
                if (do_set) begin
                    n_valid       = 1'b1;
                    n_result.kind = KIND_SET;
                    n_result.last = 1'b1;
                    if (free_found) begin
                        n_result.result_id = next_id;
                        n_result.slot      = to_slot_field(free_idx);
                    end else begin
                        n_result.full_res = 1'b1;
                    end
                end else if (do_clear) begin
                    n_valid       = 1'b1;
                    n_result.kind = KIND_CLEAR;
                    n_result.last = 1'b1;
                end
            end
            B_SCAN: begin
                if (fire_now) begin
                    n_valid                 = 1'b1;
                    n_result.kind           = KIND_FIRE;
                    n_result.result_id      = r_id[r_idx];
                    n_result.slot           = to_slot_field(r_idx);
                    n_result.fired_handler  = r_handler[r_idx];
                    n_result.fired_argument = r_arg[r_idx];
                end
            end
            B_DONE: begin
                n_valid       = 1'b1;
                n_result.kind = KIND_TICK_DONE;
                n_result.last = 1'b1;
            end
            default: n_valid = 1'b0;
        endcase
    end

    // Control state: sequencer, slot occupancy, ids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_valid  <= 1'b0;
            r_id_ctr <= '0;
            r_idx    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_running[i] <= 1'b0;
                r_id[i]      <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            // claim a slot
            if (do_set && free_found) begin
                r_running[free_idx] <= 1'b1;
                r_id[free_idx]      <= next_id;
                r_id_ctr            <= next_id;
            end
            // drop every slot with a matching id
            if (do_clear) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_id[i] == i_q_cmd.timer_id) begin
                        r_running[i] <= 1'b0;
                    end
                end
            end
            // walk the slots
            if (do_tick) begin
                r_idx <= '0;
            end else if (r_state == B_SCAN) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                if (fire_now && done_now) begin
                    r_running[r_idx] <= 1'b0;
                end
            end
        end
    end

    // Slot payload and result register
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (do_tick) begin
            r_now <= i_q_cmd.now_ms;
        end
        if (do_set && free_found) begin
            r_interval[free_idx] <= i_q_cmd.interval;
            r_last[free_idx]     <= i_q_cmd.now_ms;
            r_repeat[free_idx]   <= i_q_cmd.repeat_req;
            r_count[free_idx]    <= 16'd0;
            r_handler[free_idx]  <= i_q_cmd.handler;
            r_arg[free_idx]      <= i_q_cmd.argument;
        end
        if ((r_state == B_SCAN) && fire_now) begin
            r_last[r_idx]  <= r_now;
            r_count[r_idx] <= count_inc;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/msit_checker.sv */
// Port-level checker for the multi-slot interval timer, bound to the top level.
// Depends on msit_pkg and multi_slot_interval_timer_defines.svh.
`include "multi_slot_interval_timer_defines.svh"

module msit_checker
    import msit_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input t_out o_result,
    input logic o_valid
);

    logic set_beat;
    logic done_beat;
    logic fire_beat;
    logic full_beat;
    logic no_id_slot;

    // Classify the beat on the result ports
    assign set_beat   = o_valid && (o_result.kind == KIND_SET);
    assign done_beat  = o_valid && (o_result.kind == KIND_TICK_DONE);
    assign fire_beat  = o_valid && (o_result.kind == KIND_FIRE);
    assign full_beat  = o_valid && o_result.full_res;
    assign no_id_slot = (o_result.result_id == 16'd0) && (o_result.slot == 3'd0);

    // No result beat right after reset
    `MSIT_ASSERT_NEXT(a_quiet_after_reset, i_clk, !i_rst_n, !o_valid)

    // Set and tick-done beats close their command
    `MSIT_ASSERT_IMPLY(a_set_last, i_clk, i_rst_n, set_beat, o_result.last)
    `MSIT_ASSERT_IMPLY(a_tick_done_last, i_clk, i_rst_n, done_beat, o_result.last)

    // A fire beat never closes a tick
    `MSIT_ASSERT_IMPLY(a_fire_not_last, i_clk, i_rst_n, fire_beat, !o_result.last)

    // A full reply carries no id and no slot
    `MSIT_ASSERT_IMPLY(a_full_empty, i_clk, i_rst_n, full_beat, no_id_slot)

endmodule

bind multi_slot_interval_timer msit_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_result (o_result),
    .o_valid  (o_valid)
);

/* tb/sv/multi_slot_interval_timer_tb.sv */
// Testbench for the multi-slot interval timer: directed, random and mixed-repeat tests.
// Checks every result beat against an in-bench model of the slot table.
// Depends on msit_pkg and the multi_slot_interval_timer RTL.
`timescale 1ns / 100ps

module multi_slot_interval_timer_tb;
    import msit_pkg::*;

    // Action code that the block drops without an answer
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Idle cycles tolerated with no beat moving either way
    localparam int STALL_LIMIT = 2000;
    // Set and tick rounds of the mixed-repeat test
    localparam int MIX_ROUNDS = 12;
    localparam int MAX_PRINTED = 40;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_cmd = '0;
    logic o_valid;
    t_out o_result;

    // Model of the slot table
    bit                 tm_running [SLOTS];
    logic [15:0]        tm_id      [SLOTS];
    logic [15:0]        tm_interval[SLOTS];
    logic [31:0]        tm_last    [SLOTS];
    logic [15:0]        tm_repeat  [SLOTS];
    logic [15:0]        tm_count   [SLOTS];
    logic [7:0]         tm_handler [SLOTS];
    logic signed [15:0] tm_arg     [SLOTS];
    logic [15:0]        id_ctr;

    // Result beats predicted but not yet seen
    t_out due_beats[$];
    t_out want_beat;

    int          mismatch_cnt = 0;
    int          stall_cnt = 0;
    logic [31:0] cur_now = '0;

    multi_slot_interval_timer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Advance the slot table by one command and queue the beats it answers with
    function automatic void timer_table_step(input t_in c);
        int          i;
        int          free_idx;
        logic [31:0] elapsed;
        t_out        b;
        free_idx = -1;
        b = '0;
        b.last = 1'b1;
        case (c.action)
            ACT_SET: begin
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!tm_running[i]) free_idx = i;
                b.kind = KIND_SET;
                if (free_idx < 0) begin
                    b.full_res = 1'b1;
                end else begin
                    id_ctr = id_ctr + 16'd1;
                    tm_id[free_idx]       = id_ctr;
                    tm_running[free_idx]  = 1'b1;
                    tm_interval[free_idx] = c.interval;
                    tm_last[free_idx]     = c.now_ms;
                    tm_repeat[free_idx]   = c.repeat_req;
                    tm_count[free_idx]    = '0;
                    tm_handler[free_idx]  = c.handler;
                    tm_arg[free_idx]      = c.argument;
                    b.result_id = id_ctr;
                    b.slot      = 3'(free_idx);
                end
                due_beats.push_back(b);
            end
            ACT_CLEAR: begin
                for (i = 0; i < SLOTS; i++)
                    if (tm_id[i] == c.timer_id) tm_running[i] = 1'b0;
                b.kind = KIND_CLEAR;
                due_beats.push_back(b);
            end
            ACT_TICK: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (tm_running[i]) begin
                        elapsed = c.now_ms - tm_last[i];
                        if (elapsed >= {16'd0, tm_interval[i]}) begin
                            tm_last[i]  = c.now_ms;
                            tm_count[i] = tm_count[i] + 16'd1;
                            b = '0;
                            b.kind           = KIND_FIRE;
                            b.result_id      = tm_id[i];
                            b.slot           = 3'(i);
                            b.fired_handler  = tm_handler[i];
                            b.fired_argument = tm_arg[i];
                            due_beats.push_back(b);
                            if (tm_repeat[i] != 16'd0 && tm_repeat[i] == tm_count[i])
                                tm_running[i] = 1'b0;
                        end
                    end
                end
                b = '0;
                b.kind = KIND_TICK_DONE;
                b.last = 1'b1;
                due_beats.push_back(b);
            end
            default: ;
        endcase
    endfunction

    function automatic t_in make_cmd(input logic [1:0] act, input logic [31:0] now,
                                     input logic [15:0] ivl, input logic [15:0] rep,
                                     input logic [7:0] hnd, input logic [15:0] arg,
                                     input logic [15:0] tid);
        t_in c;
        c.action     = act;
        c.now_ms     = now;
        c.interval   = ivl;
        c.repeat_req = rep;
        c.handler    = hnd;
        c.argument   = arg;
        c.timer_id   = tid;
        return c;
    endfunction

    // Present one beat from a rising edge and hold it until taken
    task automatic send_cmd(input t_in c);
        start <= 1'b1;
        i_cmd <= c;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        timer_table_step(c);
    endtask

    // Drop start for a random stretch, pct times in a hundred
    task automatic idle_gap(input int pct);
        int n;
        if ($urandom_range(99) < pct) begin
            n = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every predicted beat has come
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (due_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic clear_all_slots();
        int i;
        for (i = 0; i < SLOTS; i++)
            if (tm_running[i])
                send_cmd(make_cmd(ACT_CLEAR, cur_now, '0, '0, '0, '0, tm_id[i]));
        wait_drain();
    endtask

    function automatic t_in random_cmd();
        int   r;
        t_in  c;
        r = $urandom_range(99);
        if ($urandom_range(15) == 0)
            cur_now = $urandom();
        else
            cur_now = cur_now + 32'($urandom_range(0, 40));
        c.now_ms     = cur_now;
        c.interval   = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 60));
        c.repeat_req = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
        c.handler    = 8'($urandom());
        c.argument   = 16'($urandom());
        c.timer_id   = ($urandom_range(3) == 0) ? 16'($urandom())
                                                : tm_id[$urandom_range(SLOTS - 1)];
        if (r < 4)
            c.action = ACT_UNUSED;
        else if (r < 40)
            c.action = ACT_SET;
        else if (r < 58)
            c.action = ACT_CLEAR;
        else
            c.action = ACT_TICK;
        return c;
    endfunction

    // Extremes of the fields and each corner of the slot table
    task automatic test_directed_cases();
        int k;
        send_cmd(make_cmd(ACT_TICK, 32'h0, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(ACT_SET, 32'h0, 16'd0, 16'd1, 8'hFF, 16'h8000, 16'hFFFF));
        send_cmd(make_cmd(ACT_TICK, 32'h0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(ACT_SET, 32'hFFFF_FFF0, 16'hFFFF, 16'd0, 8'h00, 16'h7FFF, '0));
        send_cmd(make_cmd(ACT_TICK, 32'h0000_FFEE, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(ACT_TICK, 32'h0000_FFEF, '0, '0, '0, '0, '0));
        // Fill the table, then one set too many
        for (k = 1; k < SLOTS; k++)
            send_cmd(make_cmd(ACT_SET, 32'h0001_0000, 16'(5 * k), 16'(k), 8'(k),
                              16'(-k), '0));
        send_cmd(make_cmd(ACT_SET, 32'h0001_0000, 16'd1, 16'd1, 8'hA5, 16'h5A5A, '0));
        send_cmd(make_cmd(ACT_CLEAR, 32'h0001_0000, '0, '0, '0, '0, 16'h1234));
        send_cmd(make_cmd(ACT_CLEAR, 32'h0001_0000, '0, '0, '0, '0, tm_id[1]));
        // Same id again hits a free slot, which must stay free
        send_cmd(make_cmd(ACT_CLEAR, 32'h0001_0000, '0, '0, '0, '0, tm_id[1]));
        send_cmd(make_cmd(ACT_SET, 32'h0001_0000, 16'd3, 16'hFFFF, 8'h3C, 16'h0001, '0));
        send_cmd(make_cmd(ACT_UNUSED, '1, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(ACT_TICK, 32'h0001_0028, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(ACT_UNUSED, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(ACT_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0, '0));
        cur_now = 32'hFFFF_FFFF;
        clear_all_slots();
    endtask

    task automatic test_random_traffic(input int pct, input int count, input bit drain_midway);
        int n;
        for (n = 0; n < count; n++) begin
            if (drain_midway && n == count / 2)
                wait_drain();
            idle_gap(pct);
            send_cmd(random_cmd());
        end
        wait_drain();
    endtask

    // Forever, long-repeat and one-shot slots side by side, most at interval zero
    task automatic test_mixed_repeat_slots();
        int n;
        clear_all_slots();
        send_cmd(make_cmd(ACT_SET, cur_now, 16'd0, 16'd0, 8'h11, 16'h1111, '0));
        send_cmd(make_cmd(ACT_SET, cur_now, 16'd0, 16'hFFFF, 8'h22, 16'h2222, '0));
        send_cmd(make_cmd(ACT_SET, cur_now, 16'hFFFF, 16'd0, 8'h33, 16'h3333, '0));
        for (n = 0; n < MIX_ROUNDS; n++) begin
            send_cmd(make_cmd(ACT_SET, cur_now, 16'd0, 16'd1, 8'(n), 16'(n), '0));
            send_cmd(make_cmd(ACT_TICK, cur_now, '0, '0, '0, '0, '0));
        end
        clear_all_slots();
    endtask

    // Compare each result beat with the oldest prediction
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (due_beats.size() == 0) begin
                report_mismatch("unexpected beat, kind", o_result.kind, 0);
            end else begin
                want_beat = due_beats.pop_front();
                if (o_result.kind != want_beat.kind)
                    report_mismatch("kind", o_result.kind, want_beat.kind);
                if (o_result.result_id != want_beat.result_id)
                    report_mismatch("result_id", o_result.result_id, want_beat.result_id);
                if (o_result.full_res != want_beat.full_res)
                    report_mismatch("full_res", o_result.full_res, want_beat.full_res);
                if (o_result.slot != want_beat.slot)
                    report_mismatch("slot", o_result.slot, want_beat.slot);
                if (o_result.fired_handler != want_beat.fired_handler)
                    report_mismatch("fired_handler", o_result.fired_handler,
                                    want_beat.fired_handler);
                if (o_result.fired_argument !== want_beat.fired_argument)
                    report_mismatch("fired_argument", 16'(o_result.fired_argument),
                                    16'(want_beat.fired_argument));
                if (o_result.last != want_beat.last)
                    report_mismatch("last", o_result.last, want_beat.last);
            end
        end
    end

    // End the run when no beat moves for too long
    always @(negedge i_clk) begin
        if (o_valid || (start && !busy))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int i;
        for (i = 0; i < SLOTS; i++) begin
            tm_running[i]  = 1'b0;
            tm_id[i]       = '0;
            tm_interval[i] = '0;
            tm_last[i]     = '0;
            tm_repeat[i]   = '0;
            tm_count[i]    = '0;
            tm_handler[i]  = '0;
            tm_arg[i]      = '0;
        end
        id_ctr = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(0, 100, 1'b0);
        test_random_traffic(60, 100, 1'b1);
        test_random_traffic(37, 100, 1'b0);
        test_mixed_repeat_slots();

        wait_drain();
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        if (due_beats.size() != 0)
            report_mismatch("beats never seen, count", due_beats.size(), 0);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/msit_pkg.sv
design/msit_front.sv
design/msit_queue.sv
design/msit_back.sv
design/multi_slot_interval_timer.sv
design/msit_checker.sv
tb/sv/multi_slot_interval_timer_tb.sv
